FILE: hw/rtl/jackknife_bin_means_core_macros.svh
// ----------------------------------------------------------------------------
// jackknife_bin_means_core_macros
// Assertion macros shared by the jackknife bin means RTL.
// ----------------------------------------------------------------------------
`ifndef JACKKNIFE_BIN_MEANS_CORE_MACROS_SVH
`define JACKKNIFE_BIN_MEANS_CORE_MACROS_SVH
`ifndef SYNTH
// Antecedent and consequent in the same cycle.
`define JBM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("jbm assertion failed");
// Consequent in the cycle after the antecedent.
`define JBM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("jbm assertion failed");
`else
`define JBM_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define JBM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/jbm_pkg.sv
// ----------------------------------------------------------------------------
// jbm_pkg
// Widths, register indexes and control types of the jackknife bin means core.
// ----------------------------------------------------------------------------
package jbm_pkg;

	localparam int SAMPLE_W    = 32;
	localparam int ACC_W       = 42;
	localparam int NUM_W       = ACC_W + 1;
	localparam int CNT_W       = 11;
	localparam int POS_W       = 10;
	localparam int NB_W        = 7;
	localparam int IDX_W       = 6;
	localparam int MEAN_W      = 32;
	localparam int QUO_W       = MEAN_W - 1;
	localparam int DIV_W       = 11;
	localparam int HI_W        = NUM_W - QUO_W;
	localparam int STEP_W      = $clog2(QUO_W);
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 11;

	localparam int MAX_SAMPLES_C = 1024;
	localparam int MAX_BINS_C    = 64;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_SAMPLES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BIN_SIZE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_BINS    = 2'd2;

	localparam logic [CNT_W-1:0]  NUM_SAMPLES_RST = 11'd2;
	localparam logic [POS_W-1:0]  BIN_SIZE_RST    = 10'd1;
	localparam logic [NB_W-1:0]   NUM_BINS_RST    = 7'd1;

	localparam logic [MEAN_W-1:0] MEAN_MAX = 32'h7FFF_FFFF;
	localparam logic [MEAN_W-1:0] MEAN_MIN = 32'h8000_0000;

	typedef struct packed {
		logic accept;
		logic rd_en;
		logic sub_en;
		logic abs_en;
		logic chk_en;
		logic div_step;
		logic out_load;
		logic out_last;
	} jbm_cmd_t;

	typedef struct packed {
		logic            series_end;
		logic [NB_W-1:0] nb;
		logic            skip_div;
	} jbm_status_t;

endpackage

FILE: hw/rtl/jackknife_bin_means_core.sv
// ----------------------------------------------------------------------------
// jackknife_bin_means_core
// Binned jackknife means over a series of Q16.16 samples.
// ----------------------------------------------------------------------------
// Samples are taken one word per cycle while the core is collecting a series;
// each updates the running total and the sum of its bin. The word that
// completes a series (num_samples of them) starts the emit phase, during which
// in_stall stays high. Emit produces num_bins words in bin order, each going
// through a bin sum memory read, a subtract, a magnitude step, a range check
// and 31 steps of the one-bit-per-cycle restoring divider, then the load of
// the output register. A bin whose mean saturates, or any bin when num_samples
// is not above bin_size, skips the divider and goes on to the load. The load
// waits while the previous word is still held by out_stall. After the last
// mean is loaded the core takes samples again, even while that word waits.
// ----------------------------------------------------------------------------
`include "jackknife_bin_means_core_macros.svh"

module jackknife_bin_means_core
	import jbm_pkg::*;
#(
	parameter int MAX_BINS = MAX_BINS_C
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [SAMPLE_W-1:0]  sample,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [MEAN_W-1:0]    jackknife_mean,
	output logic [IDX_W-1:0]            bin_index,
	output logic                        last_of_run
);

	jbm_cmd_t        cmd;
	jbm_status_t     status;
	logic [NB_W-1:0] emit_idx;

	jbm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd),
		.emit_idx  (emit_idx)
	);

	jbm_datapath #(
		.MAX_BINS (MAX_BINS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.sample         (sample),
		.cmd            (cmd),
		.emit_idx       (emit_idx),
		.status         (status),
		.jackknife_mean (jackknife_mean),
		.bin_index      (bin_index),
		.last_of_run    (last_of_run)
	);

	// The word that ends a series with bins to emit must close intake.
	`JBM_ASSERT_NEXT(a_emit_closes_intake, clk, arst_n, in_valid && !in_stall && status.series_end && status.nb != '0, in_stall)
	// The final mean of a series carries the highest bin index.
	`JBM_ASSERT_SAME(a_last_is_top_bin, clk, arst_n, out_valid && last_of_run, ({1'b0, bin_index} + NB_W'(1)) == status.nb)
	// No output word is loaded over one that is held.
	`JBM_ASSERT_SAME(a_no_overwrite, clk, arst_n, cmd.out_load, !out_valid || !out_stall)

endmodule

FILE: hw/rtl/jbm_datapath.sv
// ----------------------------------------------------------------------------
// jbm_datapath
// Configuration registers, running sums, bin sum memory, restoring divider
// and the output word register.
// ----------------------------------------------------------------------------
module jbm_datapath
	import jbm_pkg::*;
#(
	parameter int MAX_BINS = MAX_BINS_C,
	localparam int BIN_AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data,
	input  logic signed [SAMPLE_W-1:0]  sample,
	input  jbm_cmd_t                    cmd,
	input  logic [NB_W-1:0]             emit_idx,
	output jbm_status_t                 status,
	output logic signed [MEAN_W-1:0]    jackknife_mean,
	output logic [IDX_W-1:0]            bin_index,
	output logic                        last_of_run
);

	logic [CNT_W-1:0] num_samples_q;
	logic [POS_W-1:0] bin_size_q;
	logic [NB_W-1:0]  num_bins_q;

	logic signed [ACC_W-1:0] total_q;
	logic signed [ACC_W-1:0] tot_q;
	logic signed [ACC_W-1:0] bin_acc_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [POS_W-1:0]        pos_q;
	logic [NB_W-1:0]         cur_bin_q;

	logic signed [ACC_W-1:0] bin_mem_q [MAX_BINS];
	logic signed [ACC_W-1:0] rd_q;

	logic signed [NUM_W-1:0] num_q;
	logic [NUM_W-1:0]        mag_q;
	logic                    sign_q;
	logic                    sat_q;
	logic [DIV_W-1:0]        rem_q;
	logic [QUO_W-1:0]        quo_q;

	logic signed [MEAN_W-1:0] mean_q;
	logic [IDX_W-1:0]         bin_index_q;
	logic                     last_q;

	logic signed [ACC_W-1:0] x_ext;
	logic signed [ACC_W-1:0] total_new;
	logic signed [ACC_W-1:0] bin_new;
	logic [CNT_W-1:0]        n_eff;
	logic [POS_W-1:0]        bsz;
	logic [NB_W-1:0]         nb;
	logic [POS_W:0]          pos_next;
	logic                    bin_close;
	logic                    bin_active;
	logic                    series_end;
	logic                    div_pos;
	logic [DIV_W-1:0]        div;
	logic [HI_W-1:0]         hi;
	logic                    ovf;
	logic                    skip;
	logic [DIV_W:0]          trial;
	logic                    trial_ge;
	logic [MEAN_W-1:0]       quo_ext;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_samples_q <= NUM_SAMPLES_RST;
			bin_size_q    <= BIN_SIZE_RST;
			num_bins_q    <= NUM_BINS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NUM_SAMPLES: num_samples_q <= cfg_data;
				REG_BIN_SIZE:    bin_size_q    <= cfg_data[POS_W-1:0];
				REG_NUM_BINS:    num_bins_q    <= cfg_data[NB_W-1:0];
				default: ;
			endcase
		end
	end

	assign n_eff = (num_samples_q > CNT_W'(MAX_SAMPLES_C)) ? CNT_W'(MAX_SAMPLES_C)
		: num_samples_q;
	assign bsz   = (bin_size_q == '0) ? POS_W'(1) : bin_size_q;
	assign nb    = (num_bins_q > NB_W'(MAX_BINS)) ? NB_W'(MAX_BINS) : num_bins_q;

	assign x_ext      = ACC_W'(sample);
	assign total_new  = total_q + x_ext;
	assign bin_new    = (pos_q == '0) ? x_ext : bin_acc_q + x_ext;
	assign pos_next   = {1'b0, pos_q} + (POS_W+1)'(1);
	assign bin_close  = pos_next >= {1'b0, bsz};
	assign bin_active = cur_bin_q < nb;
	assign series_end = ({1'b0, cnt_q} + (CNT_W+1)'(1)) >= {1'b0, n_eff};

	// Sample intake: running total, running bin sum and the position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= '0;
			cnt_q     <= '0;
			pos_q     <= '0;
			cur_bin_q <= '0;
		end else if (cmd.accept) begin
			if (series_end) begin
				total_q   <= '0;
				cnt_q     <= '0;
				pos_q     <= '0;
				cur_bin_q <= '0;
			end else begin
				total_q <= total_new;
				cnt_q   <= cnt_q + CNT_W'(1);
				if (bin_active) begin
					if (bin_close) begin
						pos_q     <= '0;
						cur_bin_q <= cur_bin_q + NB_W'(1);
					end else begin
						pos_q <= pos_next[POS_W-1:0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && bin_active) begin
			bin_acc_q <= bin_new;
		end
		if (cmd.accept && series_end) begin
			tot_q <= total_new;
		end
	end

	// Bin sum memory: one write port for intake, one registered read port for emit.
	always_ff @(posedge clk) begin
		if (cmd.accept && bin_active) begin
			bin_mem_q[cur_bin_q[BIN_AW-1:0]] <= bin_new;
		end
		if (cmd.rd_en) begin
			rd_q <= bin_mem_q[emit_idx[BIN_AW-1:0]];
		end
	end

	assign div_pos = n_eff > {1'b0, bin_size_q};
	assign div     = DIV_W'(n_eff - {1'b0, bin_size_q});
	assign hi      = mag_q[NUM_W-1:QUO_W];
	// The quotient reaches 2^31 exactly when the top bits alone reach the divisor.
	assign ovf     = hi >= HI_W'(div);
	assign skip    = !div_pos || ovf;

	assign trial    = {rem_q, quo_q[QUO_W-1]};
	assign trial_ge = trial >= {1'b0, div};
	assign quo_ext  = {1'b0, quo_q};

	// Emit path: difference, magnitude, range check, then one quotient bit a step.
	always_ff @(posedge clk) begin
		if (cmd.sub_en) begin
			num_q <= NUM_W'(tot_q) - NUM_W'(rd_q);
		end
		if (cmd.abs_en) begin
			sign_q <= num_q[NUM_W-1];
			mag_q  <= num_q[NUM_W-1] ? -num_q : num_q;
		end
		if (cmd.chk_en) begin
			sat_q <= div_pos ? ovf : (mag_q != '0);
			rem_q <= hi[DIV_W-1:0];
			quo_q <= skip ? '0 : mag_q[QUO_W-1:0];
		end else if (cmd.div_step) begin
			rem_q <= trial_ge ? DIV_W'(trial - {1'b0, div}) : trial[DIV_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], trial_ge};
		end
	end

	// Output word register.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (sat_q) begin
				mean_q <= sign_q ? MEAN_MIN : MEAN_MAX;
			end else begin
				mean_q <= sign_q ? -quo_ext : quo_ext;
			end
			bin_index_q <= emit_idx[IDX_W-1:0];
			last_q      <= cmd.out_last;
		end
	end

	assign status.series_end = series_end;
	assign status.nb         = nb;
	assign status.skip_div   = skip;

	assign jackknife_mean = mean_q;
	assign bin_index      = bin_index_q;
	assign last_of_run    = last_q;

endmodule

FILE: hw/rtl/jbm_ctrl.sv
// ----------------------------------------------------------------------------
// jbm_ctrl
// Controller: sample intake handshake, per-bin emit sequence, divider step
// count and the output word valid flag.
// ----------------------------------------------------------------------------
module jbm_ctrl
	import jbm_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	input  jbm_status_t     status,
	output jbm_cmd_t        cmd,
	output logic [NB_W-1:0] emit_idx
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_RD   = 7'b0000010,
		S_SUB  = 7'b0000100,
		S_ABS  = 7'b0001000,
		S_CHK  = 7'b0010000,
		S_DIV  = 7'b0100000,
		S_WR   = 7'b1000000
	} jbm_state_t;

	jbm_state_t        state_q;
	jbm_state_t        state_d;
	logic [NB_W-1:0]   k_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic              out_free;
	logic              last_bin;
	logic              accept;

	assign accept   = in_valid && (state_q == S_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign last_bin = (k_q + NB_W'(1)) == status.nb;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.accept = accept;
				if (accept && status.series_end && status.nb != '0) begin
					state_d = S_RD;
				end
			end
			S_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_SUB;
			end
			S_SUB: begin
				cmd.sub_en = 1'b1;
				state_d    = S_ABS;
			end
			S_ABS: begin
				cmd.abs_en = 1'b1;
				state_d    = S_CHK;
			end
			S_CHK: begin
				cmd.chk_en = 1'b1;
				state_d    = status.skip_div ? S_WR : S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == STEP_W'(QUO_W - 1)) begin
					state_d = S_WR;
				end
			end
			S_WR: begin
				cmd.out_load = out_free;
				cmd.out_last = last_bin;
				if (out_free) begin
					state_d = last_bin ? S_IDLE : S_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE) begin
				k_q <= '0;
			end else if (cmd.out_load) begin
				k_q <= k_q + NB_W'(1);
			end
			if (state_q == S_DIV) begin
				step_q <= step_q + STEP_W'(1);
			end else begin
				step_q <= '0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign emit_idx  = k_q;

endmodule

FILE: bench/jackknife_bin_means_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// jackknife_bin_means_core_tb
// Self-checking bench for the binned jackknife means core.
// ----------------------------------------------------------------------------
// Sample words are streamed in series under many register settings. A
// scoreboard keeps its own running total, bin sums and counters, works out the
// jackknife means that each series should produce and checks every output
// word against them in order. Both handshakes idle and stall in random bursts.
// ----------------------------------------------------------------------------

module jackknife_bin_means_core_tb;
	import jbm_pkg::*;

	localparam int DRAIN_CYCLES   = 64;
	localparam int RANDOM_SAMPLES = 40;

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_TOP    = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_BOTTOM = {1'b1, {(SAMPLE_W-1){1'b0}}};

	typedef struct {
		logic [MEAN_W-1:0] mean;
		logic [IDX_W-1:0]  bin;
		logic              last;
	} mean_word_t;

	class jackknife_means_board;
		logic [CNT_W-1:0] num_samples;
		logic [POS_W-1:0] bin_size;
		logic [NB_W-1:0]  num_bins;
		logic [ACC_W-1:0] total;
		logic [ACC_W-1:0] bin_sum [MAX_BINS_C];
		logic [CNT_W-1:0] taken;
		logic [POS_W-1:0] pos;
		logic [NB_W-1:0]  cur_bin;
		mean_word_t       pending [$];
		int               errors;
		int               means_checked;
		int               samples_taken;
		int               series_done;

		function new();
			num_samples = NUM_SAMPLES_RST;
			bin_size = BIN_SIZE_RST;
			num_bins = NUM_BINS_RST;
			total = '0;
			taken = '0;
			pos = '0;
			cur_bin = '0;
			foreach (bin_sum[k])
				bin_sum[k] = '0;
			errors = 0;
			means_checked = 0;
			samples_taken = 0;
			series_done = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_NUM_SAMPLES: num_samples = data;
				REG_BIN_SIZE:    bin_size = data[POS_W-1:0];
				REG_NUM_BINS:    num_bins = data[NB_W-1:0];
				default: ;
			endcase
		endfunction

		function void take_sample(logic signed [SAMPLE_W-1:0] x);
			logic [ACC_W-1:0] x_ext;
			int               n_eff;
			int               nb;
			int               bsz;
			longint           divisor;
			longint           num;
			longint           q;
			mean_word_t       w;

			x_ext = {{(ACC_W-SAMPLE_W){x[SAMPLE_W-1]}}, x};
			n_eff = (num_samples > MAX_SAMPLES_C) ? MAX_SAMPLES_C : num_samples;
			nb = (num_bins > MAX_BINS_C) ? MAX_BINS_C : num_bins;
			bsz = (bin_size == 0) ? 1 : bin_size;
			samples_taken++;

			total = total + x_ext;
			// Only the first nb bins keep a sum; later words go to the total alone.
			if (cur_bin < nb) begin
				if (pos == 0)
					bin_sum[cur_bin] = x_ext;
				else
					bin_sum[cur_bin] = bin_sum[cur_bin] + x_ext;
				if (pos + 1 >= bsz) begin
					pos = '0;
					cur_bin++;
				end else begin
					pos++;
				end
			end

			if (taken + 1 >= n_eff) begin
				// The divisor uses the raw bin size, even when it is zero.
				divisor = longint'(n_eff) - longint'(bin_size);
				for (int k = 0; k < nb; k++) begin
					num = $signed(total) - $signed(bin_sum[k]);
					if (divisor <= 0)
						q = (num > 0) ? longint'(MEAN_MAX) :
							((num < 0) ? -longint'(MEAN_MIN) : 0);
					else
						q = num / divisor;
					if (q > longint'(MEAN_MAX))
						q = longint'(MEAN_MAX);
					if (q < -longint'(MEAN_MIN))
						q = -longint'(MEAN_MIN);
					w.mean = q[MEAN_W-1:0];
					w.bin = k[IDX_W-1:0];
					w.last = (k + 1 == nb);
					pending.push_back(w);
				end
				total = '0;
				taken = '0;
				pos = '0;
				cur_bin = '0;
				series_done++;
			end else begin
				taken++;
			end
		endfunction

		function void check_mean(logic [MEAN_W-1:0] mean, logic [IDX_W-1:0] bin, logic last);
			mean_word_t w;

			if (pending.size() == 0) begin
				errors++;
				$display("%0t: mean word %h for bin %0d with none expected", $time, mean, bin);
				return;
			end
			w = pending.pop_front();
			means_checked++;
			if (mean !== w.mean) begin
				errors++;
				$display("%0t: bin %0d jackknife_mean expected %h, got %h",
					$time, w.bin, w.mean, mean);
			end
			if (bin !== w.bin) begin
				errors++;
				$display("%0t: bin_index expected %0d, got %0d", $time, w.bin, bin);
			end
			if (last !== w.last) begin
				errors++;
				$display("%0t: bin %0d last_of_run expected %b, got %b",
					$time, w.bin, w.last, last);
			end
		endfunction
	endclass

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]        cfg_index = REG_NUM_SAMPLES;
	logic [CFG_DATA_W-1:0]       cfg_data = '0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic signed [SAMPLE_W-1:0]  sample = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic signed [MEAN_W-1:0]    jackknife_mean;
	logic [IDX_W-1:0]            bin_index;
	logic                        last_of_run;

	bit                          quiet = 1'b0;
	int                          stall_left = 0;
	int                          reg_writes = 0;
	jackknife_means_board        board = new();

	jackknife_bin_means_core i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.sample         (sample),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.jackknife_mean (jackknife_mean),
		.bin_index      (bin_index),
		.last_of_run    (last_of_run)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Output stall alternates between random stall and ready bursts.
	always @(negedge clk) begin
		if (quiet) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left = stall_left - 1;
		end else begin
			out_stall <= ($urandom_range(0, 2) == 0);
			stall_left = $urandom_range(1, 15) - 1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_mean(jackknife_mean, bin_index, last_of_run);
	end

	function automatic logic signed [SAMPLE_W-1:0] random_sample();
		case ($urandom_range(0, 9))
			0: return SAMPLE_TOP;
			1: return SAMPLE_BOTTOM;
			2: return '0;
			3: return '1;
			4, 5: return $urandom_range(0, 512) - 256;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_sample(logic signed [SAMPLE_W-1:0] x);
		int gap;

		if (!quiet && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 15);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		sample <= x;
		do @(posedge clk); while (in_stall);
		board.take_sample(x);
	endtask

	// Drop valid, let every expected mean come out, then wait out the drain
	// period, so that a word that no series should produce is still checked.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(data);
		@(posedge clk);
		board.set_reg(idx, CFG_DATA_W'(data));
		reg_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(int unsigned ns, int unsigned bs, int unsigned nb);
		settle();
		write_reg(REG_NUM_SAMPLES, ns);
		write_reg(REG_BIN_SIZE, bs);
		write_reg(REG_NUM_BINS, nb);
	endtask

	task automatic finish_series();
		do send_sample(random_sample()); while (board.taken != 0);
	endtask

	initial begin
		int unsigned ns;
		int unsigned bs;
		int unsigned nb;
		int unsigned kind;
		int unsigned mask;
		int          start_count;
		int          target;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Settings after reset, with the most positive and most negative words.
		send_sample(SAMPLE_TOP);
		send_sample(SAMPLE_BOTTOM);

		// A zero bin size bins one word per bin, yet the divisor subtracts zero.
		set_config(4, 0, 2);
		send_sample('0);
		send_sample(1);
		send_sample('1);
		send_sample(32'sh1234_5678);

		// A zero sample count ends the series on every word and leaves no
		// divisor: zero, positive and negative numerators all show up here.
		settle();
		write_reg(REG_NUM_SAMPLES, 0);
		send_sample(32'sh4000_0000);
		send_sample(-5);
		set_config(1, 1, 2);
		send_sample('0);

		// No bins: the series restarts without a word.
		set_config(3, 1, 0);
		repeat (3) send_sample(random_sample());

		// Shrink the bin while it is open and drop the count to the number already
		// taken, so the next word closes the bin and ends the series.
		set_config(10, 4, 2);
		repeat (3) send_sample(random_sample());
		settle();
		write_reg(REG_BIN_SIZE, 2);
		write_reg(REG_NUM_SAMPLES, 3);
		send_sample(random_sample());

		// Quotient that saturates at the range check, beside one that divides.
		set_config(4, 3, 2);
		repeat (3) send_sample(SAMPLE_TOP);
		send_sample('0);

		// Bin count above the limit acts as the limit; this also fills every bin.
		set_config(64, 1, 127);
		finish_series();

		start_count = board.samples_taken;
		target = RANDOM_SAMPLES;
		while (board.samples_taken - start_count < target) begin
			if (target - (board.samples_taken - start_count) <= RANDOM_SAMPLES / 5)
				quiet = 1'b1;
			kind = $urandom_range(0, 99);
			if (kind < 50) begin
				ns = $urandom_range(2, 24);
				bs = $urandom_range(1, (ns < 6) ? ns : 6);
				nb = $urandom_range(1, ns / bs);
				set_config(ns, bs, nb);
				finish_series();
			end else if (kind < 60) begin
				ns = $urandom_range(24, 64);
				nb = $urandom_range(ns / 2, ns);
				set_config(ns, 1, nb);
				finish_series();
			end else if (kind < 80) begin
				// Settings outside the documented ranges.
				set_config($urandom_range(0, 12), $urandom_range(0, 15),
					$urandom_range(0, 127));
				finish_series();
			end else begin
				ns = $urandom_range(6, 24);
				bs = $urandom_range(1, 3);
				nb = $urandom_range(1, ns / bs);
				set_config(ns, bs, nb);
				repeat ($urandom_range(1, ns - 2)) send_sample(random_sample());
				settle();
				mask = $urandom_range(1, 7);
				if (mask[0])
					write_reg(REG_NUM_SAMPLES, $urandom_range(0, 30));
				if (mask[1])
					write_reg(REG_BIN_SIZE, $urandom_range(0, 8));
				if (mask[2])
					write_reg(REG_NUM_BINS, $urandom_range(0, 64));
				finish_series();
			end
		end

		quiet = 1'b1;
		settle();
		$display("Run covered %0d samples in %0d series under %0d register writes.",
			board.samples_taken, board.series_done, reg_writes);
		$display("%0d jackknife means checked, %0d errors found.",
			board.means_checked, board.errors);
		if (board.errors == 0)
			$display("jackknife_bin_means_core: match");
		else
			$display("jackknife_bin_means_core: mismatch");
		$finish;
	end

	initial begin
		#150_000_000;
		$display("Timed out waiting for the core.");
		$display("jackknife_bin_means_core: mismatch");
		$finish;
	end

endmodule
